[src/pfe_pkg.sv]
package pfe_pkg;

    // Term class codes held in the slot registers; codes above TERM_NONE act as none
    typedef enum logic [2:0] {
        TERM_CONST = 3'd0,
        TERM_LIN   = 3'd1,
        TERM_QUAD  = 3'd2,
        TERM_CUBE  = 3'd3,
        TERM_NONE  = 3'd4
    } t_term;

    // Configuration register indexes (byte address / 4)
    typedef enum logic [2:0] {
        REG_VAR_COUNT = 3'd0,
        REG_SLOT0     = 3'd1,
        REG_SLOT1     = 3'd2,
        REG_SLOT2     = 3'd3,
        REG_SLOT3     = 3'd4
    } t_reg;

    // Sequencer states
    typedef enum logic [2:0] {
        S_LOAD,
        S_SLOT,
        S_MUL1,
        S_SAT1,
        S_MUL2,
        S_SAT2,
        S_EMIT
    } t_state;

    localparam logic signed [31:0] ONE_Q16     = 32'sh0001_0000;
    localparam int                 SLOT_REGS   = 4;

    localparam logic [1:0] RST_VAR_COUNT = 2'd3;
    localparam logic [2:0] RST_SLOT0     = 3'd1;
    localparam logic [2:0] RST_SLOT1     = 3'd2;
    localparam logic [2:0] RST_SLOT2     = 3'd3;
    localparam logic [2:0] RST_SLOT3     = 3'd4;

    // Number of features one slot yields for n used elements (n is at most 3)
    function automatic logic [5:0] term_count(input logic [2:0] code, input logic [1:0] n);
        logic [5:0] cnt;
        cnt = 6'd0;
        unique case (code)
            TERM_CONST: cnt = 6'd1;
            TERM_LIN:   cnt = {4'd0, n};
            TERM_QUAD: begin
                unique case (n)
                    2'd0: cnt = 6'd0;
                    2'd1: cnt = 6'd1;
                    2'd2: cnt = 6'd3;
                    2'd3: cnt = 6'd6;
                    default: cnt = 6'd0;
                endcase
            end
            TERM_CUBE: begin
                unique case (n)
                    2'd0: cnt = 6'd0;
                    2'd1: cnt = 6'd1;
                    2'd2: cnt = 6'd4;
                    2'd3: cnt = 6'd10;
                    default: cnt = 6'd0;
                endcase
            end
            default: cnt = 6'd0;
        endcase
        return cnt;
    endfunction

endpackage

[src/pfe_if.sv]
// Input word channel: one state vector element
interface pfe_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sample_value;
    logic               last_sample;

    modport source (output valid, output sample_value, output last_sample, input ready);
    modport sink   (input valid, input sample_value, input last_sample, output ready);
endinterface

// Output word channel: one feature
interface pfe_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] feature_value;
    logic               last_feature;

    modport source (output valid, output feature_value, output last_feature, input ready);
    modport sink   (input valid, input feature_value, input last_feature, output ready);
endinterface

[src/pfe_qmul.sv]
// Shared Q16.16 multiplier: product registered, then floor shift and saturation
module pfe_qmul (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    output logic signed [31:0] o_q
);

    logic signed [63:0] r_prod;
    logic signed [63:0] shifted;

    // full 64-bit product
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_a * i_b;
        end
    end

    // arithmetic shift rounds toward minus infinity; clamp to 32 bits
    always_comb begin
        shifted = r_prod >>> 16;
        if (shifted[47:31] == {17{shifted[47]}}) begin
            o_q = shifted[31:0];
        end else if (shifted[47]) begin
            o_q = 32'sh8000_0000;
        end else begin
            o_q = 32'sh7FFF_FFFF;
        end
    end

endmodule

[src/polynomial_feature_expander_unit.sv]
// Loading: one element word per cycle while the block is in its load state.
// On the last element the sequencer walks the slots: constant and linear features
// go from slot to emit, a quadratic adds a multiply and a saturate step on the
// shared multiplier, a cubic two of each; empty slots before the last feature are
// skipped, and output stalls hold emit. No input word is taken during a run. Reset
// is synchronous, active low: clears store and sequencer.
module polynomial_feature_expander_unit
    import pfe_pkg::*;
#(
    parameter int MAX_VARS   = 3,
    parameter int TERM_SLOTS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pfe_in_if.sink      i_smp,
    pfe_out_if.source   o_feat,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IW  = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
    localparam int LDW = IW + 1;
    localparam int CW  = IW + 2;
    localparam int SW  = $clog2(TERM_SLOTS) + 1;

    // configuration registers
    logic [1:0] r_var_count;
    logic [2:0] r_slot_cfg [SLOT_REGS];

    // sequencer
    t_state                r_state, n_state;
    logic [SW-1:0]         r_slot, n_slot;
    logic [IW-1:0]         r_i, n_i, r_j, n_j, r_k, n_k;
    logic [LDW-1:0]        r_load_idx, n_load_idx;
    logic [5:0]            r_total, n_total;
    logic [5:0]            r_emit_cnt, n_emit_cnt;
    logic signed [31:0]    r_op_a, n_op_a;
    logic signed [31:0]    r_res, n_res;
    logic signed [31:0]    r_store [MAX_VARS];

    // output word register
    logic               r_out_valid;
    logic signed [31:0] r_out_data;
    logic               r_out_last;

    logic               cfg_wr;
    logic               in_acc;
    logic               out_free;
    logic [1:0]         n_used;
    logic [CW-1:0]      n_ext;
    logic [CW-1:0]      i_inc, j_inc, k_inc;
    logic [5:0]         total_c;
    logic [2:0]         cur_code;
    logic [IW-1:0]      rd_idx;
    logic signed [31:0] rd_data;
    logic               mul_en;
    logic signed [31:0] mul_q;
    logic               st_wr;
    logic               st_clr;
    logic               out_load;
    logic               is_last;
    logic               adv;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_var_count   <= RST_VAR_COUNT;
            r_slot_cfg[0] <= RST_SLOT0;
            r_slot_cfg[1] <= RST_SLOT1;
            r_slot_cfg[2] <= RST_SLOT2;
            r_slot_cfg[3] <= RST_SLOT3;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                REG_VAR_COUNT: r_var_count   <= pwdata[1:0];
                REG_SLOT0:     r_slot_cfg[0] <= pwdata[2:0];
                REG_SLOT1:     r_slot_cfg[1] <= pwdata[2:0];
                REG_SLOT2:     r_slot_cfg[2] <= pwdata[2:0];
                REG_SLOT3:     r_slot_cfg[3] <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        unique case (paddr[4:2])
            REG_VAR_COUNT: prdata = {30'd0, r_var_count};
            REG_SLOT0:     prdata = {29'd0, r_slot_cfg[0]};
            REG_SLOT1:     prdata = {29'd0, r_slot_cfg[1]};
            REG_SLOT2:     prdata = {29'd0, r_slot_cfg[2]};
            REG_SLOT3:     prdata = {29'd0, r_slot_cfg[3]};
            default:       prdata = 32'd0;
        endcase
    end

    // ---------------- derived setup ----------------
    // elements in use: var_count limited by the store depth
    assign n_used = (int'(r_var_count) < MAX_VARS) ? r_var_count : 2'(MAX_VARS);
    assign n_ext  = CW'(n_used);
    assign i_inc  = CW'(r_i) + CW'(1);
    assign j_inc  = CW'(r_j) + CW'(1);
    assign k_inc  = CW'(r_k) + CW'(1);

    // features in one run; at most 4 slots of 10 each, so the 6-bit total never overflows
    always_comb begin
        total_c = 6'd0;
        for (int s = 0; s < SLOT_REGS; s++) begin
            if (s < TERM_SLOTS) begin
                total_c = total_c + term_count(r_slot_cfg[s], n_used);
            end
        end
    end

    // term class of the current slot; slots past the registers are none
    always_comb begin
        cur_code = TERM_NONE;
        for (int s = 0; s < SLOT_REGS; s++) begin
            if (s < TERM_SLOTS && int'(r_slot) == s) begin
                cur_code = r_slot_cfg[s];
            end
        end
    end

    // single store read port, address picked by step
    always_comb begin
        unique case (r_state)
            S_MUL1:  rd_idx = r_j;
            S_MUL2:  rd_idx = r_k;
            default: rd_idx = r_i;
        endcase
    end
    assign rd_data = r_store[rd_idx];

    // ---------------- shared multiplier ----------------
    assign mul_en = (r_state == S_MUL1) || (r_state == S_MUL2);

    pfe_qmul u_qmul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (r_op_a),
        .i_b   (rd_data),
        .o_q   (mul_q)
    );

    // ---------------- handshakes ----------------
    assign i_smp.ready = (r_state == S_LOAD);
    assign in_acc      = i_smp.valid & i_smp.ready;
    assign out_free    = !r_out_valid || o_feat.ready;
    assign is_last     = (r_emit_cnt == r_total - 6'd1);

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_slot     <= '0;
            r_i        <= '0;
            r_j        <= '0;
            r_k        <= '0;
            r_load_idx <= '0;
            r_total    <= '0;
            r_emit_cnt <= '0;
        end else begin
            r_state    <= n_state;
            r_slot     <= n_slot;
            r_i        <= n_i;
            r_j        <= n_j;
            r_k        <= n_k;
            r_load_idx <= st_clr ? '0 : n_load_idx;
            r_total    <= n_total;
            r_emit_cnt <= n_emit_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op_a <= n_op_a;
        r_res  <= n_res;
    end

    always_comb begin
        n_state    = r_state;
        n_slot     = r_slot;
        n_i        = r_i;
        n_j        = r_j;
        n_k        = r_k;
        n_load_idx = r_load_idx;
        n_total    = r_total;
        n_emit_cnt = r_emit_cnt;
        n_op_a     = r_op_a;
        n_res      = r_res;
        st_wr      = 1'b0;
        st_clr     = 1'b0;
        out_load   = 1'b0;
        adv        = 1'b0;

        unique case (r_state)
            S_LOAD: begin
                if (in_acc) begin
                    // elements past the used count are dropped
                    if (CW'(r_load_idx) < n_ext) begin
                        st_wr      = 1'b1;
                        n_load_idx = r_load_idx + LDW'(1);
                    end
                    if (i_smp.last_sample) begin
                        n_total    = total_c;
                        n_emit_cnt = 6'd0;
                        n_slot     = '0;
                        n_i        = '0;
                        n_j        = '0;
                        n_k        = '0;
                        if (total_c == 6'd0) begin
                            st_clr = 1'b1;
                        end else begin
                            n_state = S_SLOT;
                        end
                    end
                end
            end
            S_SLOT: begin
                case (cur_code) inside
                    TERM_CONST: begin
                        n_res   = ONE_Q16;
                        n_state = S_EMIT;
                    end
                    TERM_LIN: begin
                        if (n_used == 2'd0) begin
                            adv = 1'b1;
                        end else begin
                            n_res   = rd_data;
                            n_state = S_EMIT;
                        end
                    end
                    TERM_QUAD, TERM_CUBE: begin
                        if (n_used == 2'd0) begin
                            adv = 1'b1;
                        end else begin
                            n_op_a  = rd_data;
                            n_state = S_MUL1;
                        end
                    end
                    default: adv = 1'b1;
                endcase
            end
            S_MUL1: n_state = S_SAT1;
            S_SAT1: begin
                if (cur_code == TERM_CUBE) begin
                    n_op_a  = mul_q;
                    n_state = S_MUL2;
                end else begin
                    n_res   = mul_q;
                    n_state = S_EMIT;
                end
            end
            S_MUL2: n_state = S_SAT2;
            S_SAT2: begin
                n_res   = mul_q;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    n_emit_cnt = r_emit_cnt + 6'd1;
                    if (is_last) begin
                        st_clr  = 1'b1;
                        n_state = S_LOAD;
                    end else begin
                        n_state = S_SLOT;
                        // step the index tuple in lexicographic order, i <= j <= k
                        case (cur_code) inside
                            TERM_LIN: begin
                                if (i_inc < n_ext) n_i = IW'(i_inc);
                                else adv = 1'b1;
                            end
                            TERM_QUAD: begin
                                if (j_inc < n_ext) begin
                                    n_j = IW'(j_inc);
                                end else if (i_inc < n_ext) begin
                                    n_i = IW'(i_inc);
                                    n_j = IW'(i_inc);
                                end else begin
                                    adv = 1'b1;
                                end
                            end
                            TERM_CUBE: begin
                                if (k_inc < n_ext) begin
                                    n_k = IW'(k_inc);
                                end else if (j_inc < n_ext) begin
                                    n_j = IW'(j_inc);
                                    n_k = IW'(j_inc);
                                end else if (i_inc < n_ext) begin
                                    n_i = IW'(i_inc);
                                    n_j = IW'(i_inc);
                                    n_k = IW'(i_inc);
                                end else begin
                                    adv = 1'b1;
                                end
                            end
                            default: adv = 1'b1;
                        endcase
                    end
                end
            end
            default: n_state = S_LOAD;
        endcase

        // move to the next slot with fresh indices, or back to loading after the last slot
        if (adv) begin
            n_i = '0;
            n_j = '0;
            n_k = '0;
            if (r_slot == SW'(TERM_SLOTS - 1)) begin
                st_clr  = 1'b1;
                n_state = S_LOAD;
            end else begin
                n_slot  = r_slot + SW'(1);
                n_state = S_SLOT;
            end
        end
    end

    // ---------------- element store ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || st_clr) begin
            for (int e = 0; e < MAX_VARS; e++) begin
                r_store[e] <= '0;
            end
        end else if (st_wr) begin
            r_store[r_load_idx[IW-1:0]] <= i_smp.sample_value;
        end
    end

    // ---------------- output word register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_feat.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= r_res;
            r_out_last <= is_last;
        end
    end

    assign o_feat.valid         = r_out_valid;
    assign o_feat.feature_value = r_out_data;
    assign o_feat.last_feature  = r_out_last;

    // ---------------- assertions ----------------
    // a run never emits more words than counted at its start
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_LOAD) |-> (r_emit_cnt < r_total))
        else $error("feature count overran the run total");

    // the last word of a run returns to loading with an empty store
    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && is_last) |=> (r_state == S_LOAD && r_load_idx == '0
                                   && r_out_last && r_out_valid))
        else $error("run did not close after its last word");

    // load position stays within the store
    a_load_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_load_idx) <= MAX_VARS)
        else $error("load index beyond store depth");

    // a word is only loaded when the output register can take it
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_out_valid || o_feat.ready))
        else $error("output word overwritten");

endmodule
